// ===== hdl/bsvg_pkg.sv =====
// Shared widths, register indexes, control structs and output rounding for the step vector block.
package bsvg_pkg;

   localparam int CORDIC_ROUNDS     = 16;
   localparam int OUT_FRACTION_BITS = 8;

   localparam int TABLE_LEN  = 24;
   localparam int RUN_ROUNDS = (CORDIC_ROUNDS < TABLE_LEN) ? CORDIC_ROUNDS : TABLE_LEN;
   localparam int ROUND_W    = (RUN_ROUNDS > 1) ? $clog2(RUN_ROUNDS) : 1;

   localparam int BEARING_W = 16;
   localparam int TOL_W     = 15;
   localparam int STEP_W    = 10;
   localparam int OUT_W     = 19;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 15;

   // Rotator datapath: Q30 vector components and the angle in 1/16384 degree.
   localparam int X_W    = 34;
   localparam int Z_W    = 23;
   localparam int PROD_W = X_W + STEP_W + 1;
   localparam int SHIFT  = 30 - OUT_FRACTION_BITS;

   localparam logic [CSR_IDX_W-1:0] CSR_VARIABLE_MODE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BEARING_TOLERANCE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SMALL_STEP        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_CEILING      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FIXED_STEP        = 3'd4;

   typedef struct packed {
      logic               load;
      logic               advance;
      logic [ROUND_W-1:0] round;
   } cordic_ctl_type;

   typedef struct packed {
      logic mul_en;
      logic sel_y;
   } scale_ctl_type;

   // Round to nearest with ties away from zero, then saturate to the output range.
   function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
      logic [PROD_W-1:0]        mag;
      logic [PROD_W-1:0]        r;
      logic signed [OUT_W-1:0]  res;
      mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
      r   = (mag + (PROD_W'(1) << (SHIFT - 1))) >> SHIFT;
      if (p[PROD_W-1]) begin
         if (r > (PROD_W'(1) << (OUT_W - 1))) begin
            res = {1'b1, {(OUT_W-1){1'b0}}};
         end else begin
            res = -OUT_W'(r);
         end
      end else begin
         if (r > ((PROD_W'(1) << (OUT_W - 1)) - PROD_W'(1))) begin
            res = {1'b0, {(OUT_W-1){1'b1}}};
         end else begin
            res = OUT_W'(r);
         end
      end
      return res;
   endfunction

endpackage

// ===== hdl/bsvg_if.sv =====
// Valid/ready channel interfaces for bearing requests and move vector responses.
interface bsvg_req_if;
   logic                           valid;
   logic                           ready;
   logic [bsvg_pkg::BEARING_W-1:0] bearing;

   modport source (output valid, output bearing, input ready);
   modport sink   (input valid, input bearing, output ready);
endinterface

interface bsvg_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [bsvg_pkg::OUT_W-1:0] north_move;
   logic signed [bsvg_pkg::OUT_W-1:0] east_move;
   logic [bsvg_pkg::STEP_W-1:0]       step_used;

   modport source (output valid, output north_move, output east_move, output step_used,
                   input ready);
   modport sink   (input valid, input north_move, input east_move, input step_used,
                   output ready);
endinterface

// ===== hdl/bsvg_cordic.sv =====
// Rotation-mode CORDIC with angle reduction, one micro-rotation per cycle while advance is set.
module bsvg_cordic (
   input  logic                                 clock,
   input  bsvg_pkg::cordic_ctl_type             ctl,
   input  logic [bsvg_pkg::BEARING_W-1:0]       bearing,
   output logic signed [bsvg_pkg::X_W-1:0]      x_out,
   output logic signed [bsvg_pkg::X_W-1:0]      y_out
);

   localparam logic [15:0] TWO_TURNS    = 16'd46080;
   localparam logic [15:0] FULL_TURN    = 16'd23040;
   localparam logic [15:0] HALF_TURN    = 16'd11520;
   localparam logic [15:0] QUARTER_TURN = 16'd5760;
   localparam logic [15:0] THREE_QUARTER = 16'd17280;
   localparam logic signed [bsvg_pkg::X_W-1:0] GAIN_Q30 = 34'sd652032874;

   localparam logic [19:0] ATAN_TAB [0:bsvg_pkg::TABLE_LEN-1] = '{
      20'd737280, 20'd435242, 20'd229970, 20'd116736, 20'd58595, 20'd29326,
      20'd14667, 20'd7334, 20'd3667, 20'd1833, 20'd917, 20'd458,
      20'd229, 20'd115, 20'd57, 20'd29, 20'd14, 20'd7,
      20'd4, 20'd2, 20'd1, 20'd0, 20'd0, 20'd0
   };

   logic signed [bsvg_pkg::X_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [bsvg_pkg::Z_W-1:0] z_ff, z_in;
   logic                            flip_ff, flip_in;

   logic [15:0]                     a_mod;
   logic signed [15:0]              a_fold;
   logic                            a_flip;
   logic signed [bsvg_pkg::X_W-1:0] dx, dy;
   logic signed [bsvg_pkg::Z_W-1:0] dz;

   always_comb begin
      if (bearing >= TWO_TURNS) begin
         a_mod = bearing - TWO_TURNS;
      end else if (bearing >= FULL_TURN) begin
         a_mod = bearing - FULL_TURN;
      end else begin
         a_mod = bearing;
      end
      // Fold into the right half plane; the back half is negated afterwards.
      if (a_mod > THREE_QUARTER) begin
         a_fold = signed'(a_mod - FULL_TURN);
         a_flip = 1'b0;
      end else if (a_mod > QUARTER_TURN) begin
         a_fold = signed'(a_mod - HALF_TURN);
         a_flip = 1'b1;
      end else begin
         a_fold = signed'(a_mod);
         a_flip = 1'b0;
      end
   end

   assign dx = x_ff >>> ctl.round;
   assign dy = y_ff >>> ctl.round;
   assign dz = signed'(bsvg_pkg::Z_W'(ATAN_TAB[5'(ctl.round)]));

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      flip_in = flip_ff;
      if (ctl.load) begin
         x_in    = GAIN_Q30;
         y_in    = '0;
         z_in    = bsvg_pkg::Z_W'(a_fold) <<< 8;
         flip_in = a_flip;
      end else if (ctl.advance) begin
         if (!z_ff[bsvg_pkg::Z_W-1]) begin
            x_in = x_ff - dy;
            y_in = y_ff + dx;
            z_in = z_ff - dz;
         end else begin
            x_in = x_ff + dy;
            y_in = y_ff - dx;
            z_in = z_ff + dz;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
   end

   assign x_out = flip_ff ? -x_ff : x_ff;
   assign y_out = flip_ff ? -y_ff : y_ff;

endmodule

// ===== hdl/bsvg_scale.sv =====
// Shared multiplier that scales one vector component by the step, with registered product.
module bsvg_scale (
   input  logic                              clock,
   input  bsvg_pkg::scale_ctl_type           ctl,
   input  logic signed [bsvg_pkg::X_W-1:0]   x_in_comp,
   input  logic signed [bsvg_pkg::X_W-1:0]   y_in_comp,
   input  logic [bsvg_pkg::STEP_W-1:0]       step,
   output logic signed [bsvg_pkg::OUT_W-1:0] rounded
);

   logic signed [bsvg_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [bsvg_pkg::X_W-1:0]    operand;
   logic signed [bsvg_pkg::STEP_W:0]   step_s;

   assign operand = ctl.sel_y ? y_in_comp : x_in_comp;
   assign step_s  = signed'({1'b0, step});

   always_comb begin
      prod_in = prod_ff;
      if (ctl.mul_en) begin
         prod_in = operand * step_s;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign rounded = bsvg_pkg::round_sat(prod_ff);

endmodule

// ===== hdl/bearing_step_vector_generator.sv =====
// Top level: step selection, sequencer, configuration registers and response register.
// A bearing passes a load step, 16 rounds on the shared add/shift rotator, two multiplier
// passes and a rounding step that waits on a full output register. A new bearing is taken
// only after the previous one has left the rounding step.
// A new bearing is taken while the previous response still waits on the output register.
// Reset (synchronous, active high) restores the register defaults and the step history.
module bearing_step_vector_generator (
   input  logic                                 clock,
   input  logic                                 reset,
   bsvg_req_if.sink                             req,
   bsvg_rsp_if.source                           rsp,
   input  logic                                 csr_we,
   input  logic [bsvg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bsvg_pkg::CSR_DAT_W-1:0]       csr_wdata
);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ROT  = 3'd1;
   localparam logic [2:0] ST_MULX = 3'd2;
   localparam logic [2:0] ST_MULY = 3'd3;
   localparam logic [2:0] ST_RND  = 3'd4;

   localparam logic [bsvg_pkg::ROUND_W-1:0] LAST_ROUND =
      bsvg_pkg::ROUND_W'(bsvg_pkg::RUN_ROUNDS - 1);

   // Configuration registers.
   logic                          variable_mode_ff, variable_mode_in;
   logic [bsvg_pkg::TOL_W-1:0]    tolerance_ff, tolerance_in;
   logic [bsvg_pkg::STEP_W-1:0]   small_step_ff, small_step_in;
   logic [bsvg_pkg::STEP_W-1:0]   ceiling_ff, ceiling_in;
   logic [bsvg_pkg::STEP_W-1:0]   fixed_step_ff, fixed_step_in;

   // Step history.
   logic [bsvg_pkg::BEARING_W-1:0] last_bearing_ff, last_bearing_in;
   logic [bsvg_pkg::STEP_W-1:0]    last_step_ff, last_step_in;
   logic                           first_item_ff, first_item_in;

   // Sequencer and working registers.
   logic [2:0]                     state_ff, state_in;
   logic [bsvg_pkg::ROUND_W-1:0]   round_ff, round_in;
   logic [bsvg_pkg::STEP_W-1:0]    step_ff, step_in;
   logic signed [bsvg_pkg::OUT_W-1:0] north_hold_ff, north_hold_in;

   // Response register.
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [bsvg_pkg::OUT_W-1:0] rsp_north_ff, rsp_north_in;
   logic signed [bsvg_pkg::OUT_W-1:0] rsp_east_ff, rsp_east_in;
   logic [bsvg_pkg::STEP_W-1:0]       rsp_step_ff, rsp_step_in;

   logic                              req_beat;
   logic                              rsp_free;
   logic [bsvg_pkg::BEARING_W-1:0]    diff;
   logic [bsvg_pkg::STEP_W:0]         doubled;
   logic [bsvg_pkg::STEP_W-1:0]       step_var;
   logic [bsvg_pkg::STEP_W-1:0]       step_sel;

   bsvg_pkg::cordic_ctl_type          cordic_ctl;
   bsvg_pkg::scale_ctl_type           scale_ctl;
   logic signed [bsvg_pkg::X_W-1:0]   x_comp, y_comp;
   logic signed [bsvg_pkg::OUT_W-1:0] rounded;

   assign req.ready = (state_ff == ST_IDLE);
   assign req_beat  = req.valid && req.ready;
   // The response register may be refilled when it is empty or drains this cycle.
   assign rsp_free  = !rsp_valid_ff || rsp.ready;

   // Configuration writes; an unknown index is ignored.
   always_comb begin
      variable_mode_in = variable_mode_ff;
      tolerance_in     = tolerance_ff;
      small_step_in    = small_step_ff;
      ceiling_in       = ceiling_ff;
      fixed_step_in    = fixed_step_ff;
      if (csr_we) begin
         case (csr_index)
            bsvg_pkg::CSR_VARIABLE_MODE:     variable_mode_in = csr_wdata[0];
            bsvg_pkg::CSR_BEARING_TOLERANCE: tolerance_in     = csr_wdata;
            bsvg_pkg::CSR_SMALL_STEP:        small_step_in    = csr_wdata[bsvg_pkg::STEP_W-1:0];
            bsvg_pkg::CSR_STEP_CEILING:      ceiling_in       = csr_wdata[bsvg_pkg::STEP_W-1:0];
            bsvg_pkg::CSR_FIXED_STEP:        fixed_step_in    = csr_wdata[bsvg_pkg::STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // Step choice. The bearing difference uses the raw values and does not wrap at a full
   // turn. While the bearing holds steady the step doubles, limited by the ceiling.
   always_comb begin
      diff    = (req.bearing >= last_bearing_ff) ? (req.bearing - last_bearing_ff)
                                                 : (last_bearing_ff - req.bearing);
      doubled = {last_step_ff, 1'b0};
      if (first_item_ff) begin
         step_var = small_step_ff;
      end else if (diff < {1'b0, tolerance_ff}) begin
         step_var = (doubled > {1'b0, ceiling_ff}) ? ceiling_ff
                                                   : doubled[bsvg_pkg::STEP_W-1:0];
      end else begin
         step_var = small_step_ff;
      end
      step_sel = variable_mode_ff ? step_var : fixed_step_ff;
   end

   // Sequencer: load, rotate, scale north, scale east, then hand the beat to the output.
   always_comb begin
      state_in        = state_ff;
      round_in        = round_ff;
      step_in         = step_ff;
      north_hold_in   = north_hold_ff;
      last_bearing_in = last_bearing_ff;
      last_step_in    = last_step_ff;
      first_item_in   = first_item_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp.ready;
      rsp_north_in    = rsp_north_ff;
      rsp_east_in     = rsp_east_ff;
      rsp_step_in     = rsp_step_ff;
      cordic_ctl      = '{load: 1'b0, advance: 1'b0, round: round_ff};
      scale_ctl       = '{mul_en: 1'b0, sel_y: 1'b0};
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               cordic_ctl.load = 1'b1;
               step_in         = step_sel;
               last_bearing_in = req.bearing;
               round_in        = '0;
               // Fixed mode leaves the step history untouched; the last bearing is still recorded.
               if (variable_mode_ff) begin
                  last_step_in  = step_var;
                  first_item_in = 1'b0;
               end
               state_in = ST_ROT;
            end
         end
         ST_ROT: begin
            cordic_ctl.advance = 1'b1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_MULX;
            end else begin
               round_in = round_ff + 1'b1;
            end
         end
         ST_MULX: begin
            scale_ctl.mul_en = 1'b1;
            state_in         = ST_MULY;
         end
         ST_MULY: begin
            north_hold_in    = rounded;
            scale_ctl.mul_en = 1'b1;
            scale_ctl.sel_y  = 1'b1;
            state_in         = ST_RND;
         end
         ST_RND: begin
            // Wait here while the previous response has not been taken.
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_north_in = north_hold_ff;
               rsp_east_in  = rounded;
               rsp_step_in  = step_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         variable_mode_ff <= 1'b1;
         tolerance_ff     <= 15'd640;
         small_step_ff    <= 10'd10;
         ceiling_ff       <= 10'd640;
         fixed_step_ff    <= 10'd10;
         last_bearing_ff  <= '0;
         last_step_ff     <= 10'd10;
         first_item_ff    <= 1'b1;
         state_ff         <= ST_IDLE;
         round_ff         <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         variable_mode_ff <= variable_mode_in;
         tolerance_ff     <= tolerance_in;
         small_step_ff    <= small_step_in;
         ceiling_ff       <= ceiling_in;
         fixed_step_ff    <= fixed_step_in;
         last_bearing_ff  <= last_bearing_in;
         last_step_ff     <= last_step_in;
         first_item_ff    <= first_item_in;
         state_ff         <= state_in;
         round_ff         <= round_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      north_hold_ff <= north_hold_in;
      rsp_north_ff  <= rsp_north_in;
      rsp_east_ff   <= rsp_east_in;
      rsp_step_ff   <= rsp_step_in;
   end

   bsvg_cordic u_cordic (
      .clock   (clock),
      .ctl     (cordic_ctl),
      .bearing (req.bearing),
      .x_out   (x_comp),
      .y_out   (y_comp)
   );

   bsvg_scale u_scale (
      .clock     (clock),
      .ctl       (scale_ctl),
      .x_in_comp (x_comp),
      .y_in_comp (y_comp),
      .step      (step_ff),
      .rounded   (rounded)
   );

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.north_move = rsp_north_ff;
   assign rsp.east_move  = rsp_east_ff;
   assign rsp.step_used  = rsp_step_ff;

   // An accepted bearing always starts the rotation in the next cycle.
   a_beat_starts_rotation: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> (state_ff == ST_ROT && round_ff == '0))
      else $error("accepted bearing did not start the rotation");

   // The last rotation round hands over to the multiplier.
   a_rotation_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROT && round_ff == LAST_ROUND) |=> (state_ff == ST_MULX))
      else $error("rotation did not end after the last round");

   // A response beat only appears out of the rounding state.
   a_rsp_from_round: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff || rsp.ready) ##1 rsp_valid_ff |-> ($past(state_ff) == ST_RND))
      else $error("response appeared without a finished item");

   // A finished item never overwrites a response that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |=> $stable(rsp_north_ff) && $stable(rsp_east_ff))
      else $error("pending response overwritten");

endmodule
